// ===== src/eabv_pkg.sv =====
package eabv_pkg;

   typedef struct packed {
      logic [15:0] yaw;
      logic [15:0] pitch;
      logic [15:0] roll;
   } req_type;

   typedef struct packed {
      logic signed [15:0] forward_x;
      logic signed [15:0] forward_y;
      logic signed [15:0] forward_z;
      logic signed [15:0] right_x;
      logic signed [15:0] right_y;
      logic signed [15:0] right_z;
      logic signed [15:0] up_x;
      logic signed [15:0] up_y;
      logic signed [15:0] up_z;
   } rsp_type;

   localparam int IntFrac = 30;
   localparam int AtanCount = 30;
   localparam logic signed [33:0] GainQ30 = 34'sd652032874;

   function automatic logic signed [33:0] atan_turn(input int i);
      logic [31:0] t;
      case (i)
         0: t = 32'h20000000;  1: t = 32'h12E4051D;  2: t = 32'h09FB385B;
         3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
         6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
         9: t = 32'h00145F2E;  10: t = 32'h000A2F98; 11: t = 32'h000517CC;
         12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2F9;
         15: t = 32'h0000517C; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
         18: t = 32'h00000A2F; 19: t = 32'h00000517; 20: t = 32'h0000028B;
         21: t = 32'h00000145; 22: t = 32'h000000A2; 23: t = 32'h00000051;
         24: t = 32'h00000028; 25: t = 32'h00000014; 26: t = 32'h0000000A;
         27: t = 32'h00000005; 28: t = 32'h00000002; 29: t = 32'h00000001;
         default: t = 32'h0;
      endcase
      return signed'({2'b00, t});
   endfunction

endpackage

// ===== src/eabv_cordic_lane.sv =====
module eabv_cordic_lane #(
   parameter int CORDIC_STEPS = 16,
   parameter int FRAC_BITS = 14
) (
   input  logic clock,
   input  logic [15:0] angle,
   input  logic advance,
   output logic signed [FRAC_BITS+1:0] sine,
   output logic signed [FRAC_BITS+1:0] cosine
);
   import eabv_pkg::*;

   localparam int Stages = (CORDIC_STEPS < AtanCount) ? CORDIC_STEPS : AtanCount;
   localparam int Shift = IntFrac - FRAC_BITS;
   localparam int OW = FRAC_BITS + 2;

   logic signed [33:0] x_start, y_start, z_start;
   logic [1:0] quad_start;
   logic exact_start;

   logic signed [33:0] x_ff [Stages];
   logic signed [33:0] y_ff [Stages];
   logic signed [33:0] z_ff [Stages];
   logic [1:0] quad_ff [Stages];
   logic exact_ff [Stages];

   assign x_start = GainQ30;
   assign y_start = '0;
   assign z_start = signed'({4'b0, angle[13:0], 16'b0});
   assign quad_start = angle[15:14];
   assign exact_start = (angle[13:0] == 14'd0);

   for (genvar i = 0; i < Stages; i++) begin : g_stage
      logic signed [33:0] x_cur, y_cur, z_cur;
      logic [1:0] quad_cur;
      logic exact_cur;
      logic signed [33:0] dx, dy;
      if (i == 0) begin : g_first
         assign x_cur = x_start;
         assign y_cur = y_start;
         assign z_cur = z_start;
         assign quad_cur = quad_start;
         assign exact_cur = exact_start;
      end else begin : g_next
         assign x_cur = x_ff[i-1];
         assign y_cur = y_ff[i-1];
         assign z_cur = z_ff[i-1];
         assign quad_cur = quad_ff[i-1];
         assign exact_cur = exact_ff[i-1];
      end
      assign dx = y_cur >>> i;
      assign dy = x_cur >>> i;
      always_ff @(posedge clock) begin
         if (advance) begin
            quad_ff[i] <= quad_cur;
            exact_ff[i] <= exact_cur;
            if (!z_cur[33]) begin
               x_ff[i] <= x_cur - dx;
               y_ff[i] <= y_cur + dy;
               z_ff[i] <= z_cur - atan_turn(i);
            end else begin
               x_ff[i] <= x_cur + dx;
               y_ff[i] <= y_cur - dy;
               z_ff[i] <= z_cur + atan_turn(i);
            end
         end
      end
   end

   function automatic logic signed [OW-1:0] round_out(input logic signed [33:0] v);
      logic signed [34:0] t;
      logic signed [OW-1:0] one;
      t = 35'(v);
      one = OW'(1) <<< FRAC_BITS;
      if (Shift > 0) t = (t + (35'sd1 <<< (Shift - 1))) >>> Shift;
      if (t > 35'(one)) return one;
      if (t < -35'(one)) return -one;
      return OW'(t);
   endfunction

   logic signed [OW-1:0] s, c, one;
   always_comb begin
      one = OW'(1) <<< FRAC_BITS;
      if (exact_ff[Stages-1]) begin
         s = '0;
         c = one;
      end else begin
         s = round_out(y_ff[Stages-1]);
         c = round_out(x_ff[Stages-1]);
      end
      case (quad_ff[Stages-1])
         2'd0: begin sine = s; cosine = c; end
         2'd1: begin sine = c; cosine = -s; end
         2'd2: begin sine = -s; cosine = -c; end
         default: begin sine = -c; cosine = s; end
      endcase
   end

   logic unused;
   assign unused = ^z_ff[Stages-1];
endmodule

// ===== src/eabv_merge.sv =====
module eabv_merge #(
   parameter int FRAC_BITS = 14
) (
   input  logic clock,
   input  logic advance,
   input  logic signed [FRAC_BITS+1:0] sy, cy, sp, cp, sr, cr,
   output eabv_pkg::rsp_type result
);
   import eabv_pkg::*;

   localparam int OW = FRAC_BITS + 2;
   localparam int PW = 2 * OW + 2;

   function automatic logic signed [OW+1:0] fmul(input logic signed [OW+1:0] a,
                                                input logic signed [OW+1:0] b);
      logic signed [PW+3:0] p;
      p = (PW+4)'(a) * (PW+4)'(b);
      p = (p + ((PW+4)'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      return (OW+2)'(p);
   endfunction

   function automatic logic [15:0] pack(input logic signed [OW+2:0] v);
      logic signed [OW+2:0] one;
      logic signed [OW+2:0] t;
      one = (OW+3)'(1) <<< FRAC_BITS;
      t = v;
      if (t > one) t = one;
      if (t < -one) t = -one;
      return 16'(t);
   endfunction

   logic signed [OW+1:0] sy_w, cy_w, sp_w, cp_w, sr_w, cr_w;
   assign sy_w = (OW+2)'(sy);
   assign cy_w = (OW+2)'(cy);
   assign sp_w = (OW+2)'(sp);
   assign cp_w = (OW+2)'(cp);
   assign sr_w = (OW+2)'(sr);
   assign cr_w = (OW+2)'(cr);

   logic signed [OW+1:0] cy_ff, sy_ff;
   logic signed [OW+1:0] spcy_ff, spsy_ff, crsy_ff, crcy_ff, srsy_ff, srcy_ff;
   logic signed [OW+1:0] cpcy_ff, cpsy_ff, nsrcp_ff, crcp_ff, nsp_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         cpcy_ff <= fmul(cp_w, cy_w);
         cpsy_ff <= fmul(cp_w, sy_w);
         nsp_ff <= -sp_w;
         nsrcp_ff <= fmul(-sr_w, cp_w);
         crcp_ff <= fmul(cr_w, cp_w);
         crsy_ff <= fmul(cr_w, sy_w);
         crcy_ff <= fmul(cr_w, cy_w);
         srsy_ff <= fmul(sr_w, sy_w);
         srcy_ff <= fmul(sr_w, cy_w);
         spcy_ff <= fmul(-sr_w, sp_w);
         spsy_ff <= fmul(cr_w, sp_w);
         cy_ff <= cy_w;
         sy_ff <= sy_w;
      end
   end

   logic signed [OW+1:0] a1, a2, a3, a4;
   assign a1 = fmul(spcy_ff, cy_ff);
   assign a2 = fmul(spcy_ff, sy_ff);
   assign a3 = fmul(spsy_ff, cy_ff);
   assign a4 = fmul(spsy_ff, sy_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         result.forward_x <= pack((OW+3)'(cpcy_ff));
         result.forward_y <= pack((OW+3)'(cpsy_ff));
         result.forward_z <= pack((OW+3)'(nsp_ff));
         result.right_x <= pack((OW+3)'(a1) + (OW+3)'(crsy_ff));
         result.right_y <= pack((OW+3)'(a2) - (OW+3)'(crcy_ff));
         result.right_z <= pack((OW+3)'(nsrcp_ff));
         result.up_x <= pack((OW+3)'(a3) + (OW+3)'(srsy_ff));
         result.up_y <= pack((OW+3)'(a4) - (OW+3)'(srcy_ff));
         result.up_z <= pack((OW+3)'(crcp_ff));
      end
   end
endmodule

// ===== src/euler_angles_to_basis_vectors.sv =====
// Converts yaw, pitch and roll binary angles to forward, right and up unit
// vectors in signed Q1.14. One request is taken every cycle while the
// pipeline is not stalled; each result's delay is set by the depth of the
// three unrolled CORDIC lanes plus two product stages. The whole pipeline
// stalls only when a result is waiting and the consumer is not ready.
module euler_angles_to_basis_vectors #(
   parameter int CORDIC_STEPS = 16,
   parameter int FRAC_BITS = 14
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  eabv_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output eabv_pkg::rsp_type rsp_data
);
   import eabv_pkg::*;

   localparam int Depth = ((CORDIC_STEPS < AtanCount) ? CORDIC_STEPS : AtanCount) + 2;
   localparam int OW = FRAC_BITS + 2;

   logic advance;
   logic [Depth-1:0] valid_ff;
   logic signed [OW-1:0] sy, cy, sp, cp, sr, cr;

   assign advance = !valid_ff[Depth-1] || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = valid_ff[Depth-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[Depth-2:0], req_valid};
      end
   end

   eabv_cordic_lane #(.CORDIC_STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS)) u_yaw (
      .clock, .angle(req_data.yaw), .advance,
      .sine(sy), .cosine(cy));
   eabv_cordic_lane #(.CORDIC_STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS)) u_pitch (
      .clock, .angle(req_data.pitch), .advance,
      .sine(sp), .cosine(cp));
   eabv_cordic_lane #(.CORDIC_STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS)) u_roll (
      .clock, .angle(req_data.roll), .advance,
      .sine(sr), .cosine(cr));

   eabv_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
      .clock, .advance, .sy, .cy, .sp, .cp, .sr, .cr, .result(rsp_data));

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("stalled with empty output");
   a_pass: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(valid_ff))
      else $error("pipeline moved while stalled");
endmodule
